// ===== design/rcd_pkg.sv =====
// rcd_pkg: shared widths, latencies, status codes and the sideband record
// of the rounded cone distance pipeline. No dependencies.
package rcd_pkg;

	localparam int COORD_W = 32;               // signed coordinate / distance width
	localparam int RAD_W   = COORD_W - 1;      // unsigned radius width
	localparam int DIFF_W  = COORD_W + 1;      // coordinate difference width
	localparam int SQ_IN_W = 2 * DIFF_W;       // sum of three squares
	localparam int ROOT_W  = SQ_IN_W / 2;      // integer square root width
	localparam int DVS_W   = ROOT_W;           // divisor is the axis length
	localparam int QUO_W   = DIFF_W + 3;       // quotient magnitude width
	localparam int DVD_W   = DVS_W + QUO_W - 1;// dividend magnitude width
	localparam int PROD_W  = 2 * QUO_W;        // wide product width
	localparam int OUT_W   = QUO_W + 4;        // pre-saturation distance width

	localparam int SQ_LAT = ROOT_W;            // one root bit per stage
	localparam int DV_LAT = QUO_W;             // one quotient bit per stage

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_RAD_DIFF = 2'd2
	} status_t;

	typedef struct packed {
		logic                      vld;
		logic                      zero;
		logic                      bad;
		logic                      kneg;
		logic                      kgt;
		logic [RAD_W-1:0]          ra;
		logic [RAD_W-1:0]          rb;
		logic signed [COORD_W-1:0] dr;
		logic [SQ_IN_W-1:0]        ww;
		logic signed [DVD_W-1:0]   dot;
		logic [ROOT_W-1:0]         h;
		logic [ROOT_W-1:0]         sw;
		logic [ROOT_W-1:0]         se;
		logic [ROOT_W-1:0]         ah;
		logic [ROOT_W-1:0]         rad;
		logic signed [QUO_W:0]     t;
	} side_t;

endpackage

// ===== design/rcd_isqrt.sv =====
// rcd_isqrt: pipelined integer square root, one result bit per stage.
// Depends on rcd_pkg for widths.
module rcd_isqrt import rcd_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [SQ_IN_W-1:0] x,
	output logic [ROOT_W-1:0]  root
);

	logic [SQ_IN_W-1:0] rem_s  [ROOT_W];
	logic [ROOT_W-1:0]  root_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic [SQ_IN_W-1:0] rem_in;
		logic [SQ_IN_W-1:0] trial;
		logic [ROOT_W-1:0]  root_in;

		if (k == 0) begin : g_first
			assign rem_in  = x;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// (2r + 2^b) * 2^b, root bits below b are still zero
		assign trial = (SQ_IN_W'(root_in) << (B + 1)) | (SQ_IN_W'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= root_in | (ROOT_W'(1) << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

// ===== design/rcd_div.sv =====
// rcd_div: pipelined restoring divider of a magnitude by the axis length,
// one quotient bit per stage; the sign rides along. Depends on rcd_pkg.
module rcd_div import rcd_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DVD_W-1:0] dvd,
	input  logic             neg,
	input  logic [DVS_W-1:0] dvs,
	output logic [QUO_W-1:0] quo,
	output logic             quo_neg
);

	logic [DVS_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [DVS_W-1:0] dvs_s [QUO_W];
	logic             neg_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DVS_W-1:0] rem_in;
		logic [QUO_W-1:0] low_in;
		logic [DVS_W-1:0] dvs_in;
		logic             neg_in;
		logic [DVS_W:0]   cat;
		logic [DVS_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = DVS_W'(dvd[DVD_W-1:QUO_W]);
			assign low_in = dvd[QUO_W-1:0];
			assign dvs_in = dvs;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign neg_in = neg_s[k-1];
		end

		assign cat  = {rem_in, low_in[QUO_W-1]};
		assign ge   = cat >= {1'b0, dvs_in};
		assign diff = cat - {1'b0, dvs_in};

		// dividend bits leave at the top, quotient bits enter at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DVS_W-1:0] : cat[DVS_W-1:0];
				low_s[k] <= {low_in[QUO_W-2:0], ge};
				dvs_s[k] <= dvs_in;
				neg_s[k] <= neg_in;
			end
		end
	end

	assign quo     = low_s[QUO_W-1];
	assign quo_neg = neg_s[QUO_W-1];

endmodule

// ===== design/rounded_cone_distance.sv =====
// rounded_cone_distance: signed distance from a query point to a rounded cone
// frustum. Input channel in_valid/in_ready carries endpoints a and b, radii and
// the point p (Q16.16); output channel out_valid/out_ready carries the distance
// (Q16.16, saturated) and a status code.
// Throughput: one item per cycle while the receiver does not stall. Four
// bit-serial units lie in line: the root of the axis length (33 stages), the
// axial division (36), the radial root (33) and the side division (36), plus
// 11 stages of differences, products, sums and the output register.
// The whole pipeline advances when the output register is empty or its item is
// taken; in_ready follows that condition, so when the receiver stalls every
// stage holds and no item is lost or repeated.
// A zero-length segment gives status 1, a radius difference above the length
// gives status 2, both with distance 0.
// Reset clears all valid bits; the block is ready in the first cycle after it.
// Depends on rcd_pkg, rcd_isqrt and rcd_div.
module rounded_cone_distance import rcd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] end_a_x,
	input  logic signed [COORD_W-1:0] end_a_y,
	input  logic signed [COORD_W-1:0] end_a_z,
	input  logic signed [COORD_W-1:0] end_b_x,
	input  logic signed [COORD_W-1:0] end_b_y,
	input  logic signed [COORD_W-1:0] end_b_z,
	input  logic [RAD_W-1:0]          radius_a,
	input  logic [RAD_W-1:0]          radius_b,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] distance,
	output logic [1:0]                status
);

	localparam int AH_TAP = SQ_LAT;

	logic en;
	logic out_vld_q;
	logic signed [COORD_W-1:0] distance_q;
	status_t status_q;

	assign en        = ~out_vld_q | out_ready;
	assign in_ready  = en;
	assign out_valid = out_vld_q;
	assign distance  = distance_q;
	assign status    = status_q;

	// stage 1: differences
	logic signed [COORD_W-1:0] a_v [3];
	logic signed [COORD_W-1:0] b_v [3];
	logic signed [COORD_W-1:0] p_v [3];
	logic signed [DIFF_W-1:0]  d_s1 [3];
	logic signed [DIFF_W-1:0]  w_s1 [3];
	logic signed [DIFF_W-1:0]  e_s1 [3];
	side_t side_in, side_s1;

	always_comb begin
		a_v[0] = end_a_x; a_v[1] = end_a_y; a_v[2] = end_a_z;
		b_v[0] = end_b_x; b_v[1] = end_b_y; b_v[2] = end_b_z;
		p_v[0] = point_x; p_v[1] = point_y; p_v[2] = point_z;
		side_in     = '0;
		side_in.vld = in_valid;
		side_in.ra  = radius_a;
		side_in.rb  = radius_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIFF_W'(b_v[i]) - DIFF_W'(a_v[i]);
				w_s1[i] <= DIFF_W'(p_v[i]) - DIFF_W'(a_v[i]);
				e_s1[i] <= DIFF_W'(p_v[i]) - DIFF_W'(b_v[i]);
			end
		end
	end

	// stage 2: squares and axial products
	logic signed [SQ_IN_W-1:0] dd_s2 [3];
	logic signed [SQ_IN_W-1:0] ww_s2 [3];
	logic signed [SQ_IN_W-1:0] ee_s2 [3];
	logic signed [SQ_IN_W-1:0] wd_s2 [3];
	side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				ww_s2[i] <= w_s1[i] * w_s1[i];
				ee_s2[i] <= e_s1[i] * e_s1[i];
				wd_s2[i] <= w_s1[i] * d_s1[i];
			end
		end
	end

	// stage 3: sums, radius difference
	logic signed [DVD_W-1:0] hh_sum, ww_sum, ee_sum, dot_sum;
	logic [SQ_IN_W-1:0] hh_s3, ee_s3;
	side_t side_s3_next, side_s3;

	always_comb begin
		hh_sum  = DVD_W'(dd_s2[0]) + DVD_W'(dd_s2[1]) + DVD_W'(dd_s2[2]);
		ww_sum  = DVD_W'(ww_s2[0]) + DVD_W'(ww_s2[1]) + DVD_W'(ww_s2[2]);
		ee_sum  = DVD_W'(ee_s2[0]) + DVD_W'(ee_s2[1]) + DVD_W'(ee_s2[2]);
		dot_sum = DVD_W'(wd_s2[0]) + DVD_W'(wd_s2[1]) + DVD_W'(wd_s2[2]);
		side_s3_next      = side_s2;
		side_s3_next.ww   = ww_sum[SQ_IN_W-1:0];
		side_s3_next.dot  = dot_sum;
		side_s3_next.zero = hh_sum == '0;
		side_s3_next.dr   = $signed({1'b0, side_s2.ra}) - $signed({1'b0, side_s2.rb});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s3 <= hh_sum[SQ_IN_W-1:0];
			ee_s3 <= ee_sum[SQ_IN_W-1:0];
		end
	end

	// roots of |d|^2, |w|^2, |p-b|^2
	logic [ROOT_W-1:0] h_root, sw_root, se_root;

	rcd_isqrt u_sq_h (.clk(clk), .en(en), .x(hh_s3),      .root(h_root));
	rcd_isqrt u_sq_w (.clk(clk), .en(en), .x(side_s3.ww), .root(sw_root));
	rcd_isqrt u_sq_e (.clk(clk), .en(en), .x(ee_s3),      .root(se_root));

	side_t dl_a_s [SQ_LAT];
	side_t side_p1;

	always_comb begin
		side_p1    = dl_a_s[SQ_LAT-1];
		side_p1.h  = h_root;
		side_p1.sw = sw_root;
		side_p1.se = se_root;
	end

	// stage 4: h^2, dr^2, radius check, |dot|
	logic signed [COORD_W-1:0] dr_abs;
	logic [SQ_IN_W-1:0] hsq_s4, drsq_s4;
	logic [DVD_W-1:0] dotmag_s4;
	logic dotneg_s4;
	side_t side_s4_next, side_s4;

	always_comb begin
		dr_abs = side_p1.dr[COORD_W-1] ? -side_p1.dr : side_p1.dr;
		side_s4_next     = side_p1;
		side_s4_next.bad = ROOT_W'(dr_abs[RAD_W-1:0]) > h_root;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsq_s4    <= SQ_IN_W'(h_root) * SQ_IN_W'(h_root);
			drsq_s4   <= SQ_IN_W'(dr_abs[RAD_W-1:0]) * SQ_IN_W'(dr_abs[RAD_W-1:0]);
			dotneg_s4 <= side_p1.dot[DVD_W-1];
			dotmag_s4 <= side_p1.dot[DVD_W-1] ? DVD_W'(-side_p1.dot) : DVD_W'(side_p1.dot);
		end
	end

	// stage 5: h^2 - dr^2, then its root ah
	logic [SQ_IN_W-1:0] diff_s5;
	logic [ROOT_W-1:0] ah_root;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s5 <= hsq_s4 - drsq_s4;
		end
	end

	rcd_isqrt u_sq_a (.clk(clk), .en(en), .x(diff_s5), .root(ah_root));

	// axial coordinate t = dot / h
	logic [QUO_W-1:0] t_quo;
	logic t_neg;

	rcd_div u_dv_t (
		.clk(clk), .en(en), .dvd(dotmag_s4), .neg(dotneg_s4), .dvs(side_s4.h),
		.quo(t_quo), .quo_neg(t_neg)
	);

	side_t dl_b_s [DV_LAT];
	side_t side_ah;

	always_comb begin
		side_ah    = dl_b_s[AH_TAP];
		side_ah.ah = ah_root;
	end

	// stage 6: signed t
	logic [QUO_W-1:0] tmag_s6;
	side_t side_s6_next, side_s6;

	always_comb begin
		side_s6_next   = dl_b_s[DV_LAT-1];
		side_s6_next.t = t_neg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmag_s6 <= t_quo;
		end
	end

	// stage 7: t^2; stage 8: clamped |w|^2 - t^2
	logic [PROD_W-1:0] t2_s7;
	logic [SQ_IN_W-1:0] rr_s8;
	logic [PROD_W-1:0] ww_ext;
	logic [PROD_W-1:0] rr_full;
	side_t side_s7, side_s8;

	assign ww_ext  = PROD_W'(side_s7.ww);
	assign rr_full = ww_ext - t2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s7 <= PROD_W'(tmag_s6) * PROD_W'(tmag_s6);
			rr_s8 <= (ww_ext < t2_s7) ? '0 : rr_full[SQ_IN_W-1:0];
		end
	end

	logic [ROOT_W-1:0] rad_root;

	rcd_isqrt u_sq_r (.clk(clk), .en(en), .x(rr_s8), .root(rad_root));

	side_t dl_c_s [SQ_LAT];
	side_t side_p3;

	always_comb begin
		side_p3     = dl_c_s[SQ_LAT-1];
		side_p3.rad = rad_root;
	end

	// stage 9: region products
	logic signed [PROD_W-1:0] pk1_s9, pk2_s9, pn2_s9;
	logic [2*ROOT_W-1:0] pahh_s9, pn1_s9;
	side_t side_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			pk1_s9  <= $signed({1'b0, side_p3.ah}) * $signed(side_p3.t);
			pk2_s9  <= $signed(side_p3.dr) * $signed({1'b0, side_p3.rad});
			pn2_s9  <= $signed(side_p3.dr) * $signed(side_p3.t);
			pahh_s9 <= (2*ROOT_W)'(side_p3.ah) * (2*ROOT_W)'(side_p3.h);
			pn1_s9  <= (2*ROOT_W)'(side_p3.ah) * (2*ROOT_W)'(side_p3.rad);
		end
	end

	// stage 10: region test and side numerator
	logic signed [PROD_W-1:0] k_val;
	logic signed [PROD_W-1:0] n_s10;
	side_t side_s10_next, side_s10;

	always_comb begin
		k_val = pk1_s9 - pk2_s9;
		side_s10_next      = side_s9;
		side_s10_next.kneg = k_val[PROD_W-1];
		side_s10_next.kgt  = $signed(PROD_W'(pahh_s9)) < k_val;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s10 <= $signed(PROD_W'(pn1_s9)) + pn2_s9;
		end
	end

	// stage 11: |n|
	logic [DVD_W-1:0] nmag_s11;
	logic nneg_s11;
	logic signed [PROD_W-1:0] n_abs;
	side_t side_s11;

	assign n_abs = n_s10[PROD_W-1] ? -n_s10 : n_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s11 <= n_abs[DVD_W-1:0];
			nneg_s11 <= n_s10[PROD_W-1];
		end
	end

	logic [QUO_W-1:0] n_quo;
	logic n_neg;

	rcd_div u_dv_n (
		.clk(clk), .en(en), .dvd(nmag_s11), .neg(nneg_s11), .dvs(side_s11.h),
		.quo(n_quo), .quo_neg(n_neg)
	);

	side_t dl_d_s [DV_LAT];
	side_t fin;

	assign fin = dl_d_s[DV_LAT-1];

	// final select and saturation
	logic signed [OUT_W-1:0] q_ext, dist_w;
	logic fits;
	logic signed [COORD_W-1:0] dist_sat, dist_next;
	status_t status_next;

	always_comb begin
		q_ext = n_neg ? -$signed(OUT_W'(n_quo)) : $signed(OUT_W'(n_quo));
		if (fin.kneg) begin
			dist_w = $signed(OUT_W'(fin.sw)) - $signed(OUT_W'(fin.ra));
		end else if (fin.kgt) begin
			dist_w = $signed(OUT_W'(fin.se)) - $signed(OUT_W'(fin.rb));
		end else begin
			dist_w = q_ext - $signed(OUT_W'(fin.ra));
		end
		fits = (dist_w[OUT_W-1:COORD_W-1] == '0) || (dist_w[OUT_W-1:COORD_W-1] == '1);
		if (fits) begin
			dist_sat = dist_w[COORD_W-1:0];
		end else if (dist_w[OUT_W-1]) begin
			dist_sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			dist_sat = {1'b0, {(COORD_W-1){1'b1}}};
		end
		if (fin.zero) begin
			status_next = ST_ZERO_LEN;
			dist_next   = '0;
		end else if (fin.bad) begin
			status_next = ST_RAD_DIFF;
			dist_next   = '0;
		end else begin
			status_next = ST_OK;
			dist_next   = dist_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			distance_q <= dist_next;
			status_q   <= status_next;
		end
	end

	// sideband records and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1   <= '0;
			side_s2   <= '0;
			side_s3   <= '0;
			side_s4   <= '0;
			side_s6   <= '0;
			side_s7   <= '0;
			side_s8   <= '0;
			side_s9   <= '0;
			side_s10  <= '0;
			side_s11  <= '0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < SQ_LAT; k++) begin
				dl_a_s[k] <= '0;
				dl_c_s[k] <= '0;
			end
			for (int k = 0; k < DV_LAT; k++) begin
				dl_b_s[k] <= '0;
				dl_d_s[k] <= '0;
			end
		end else if (en) begin
			side_s1   <= side_in;
			side_s2   <= side_s1;
			side_s3   <= side_s3_next;
			side_s4   <= side_s4_next;
			side_s6   <= side_s6_next;
			side_s7   <= side_s6;
			side_s8   <= side_s7;
			side_s9   <= side_p3;
			side_s10  <= side_s10_next;
			side_s11  <= side_s10;
			out_vld_q <= fin.vld;
			dl_a_s[0] <= side_s3;
			dl_c_s[0] <= side_s8;
			for (int k = 1; k < SQ_LAT; k++) begin
				dl_a_s[k] <= dl_a_s[k-1];
				dl_c_s[k] <= dl_c_s[k-1];
			end
			dl_b_s[0] <= side_s4;
			dl_d_s[0] <= side_s11;
			for (int k = 1; k < DV_LAT; k++) begin
				// ah joins the record when its root leaves the pipe
				if (k == AH_TAP + 1) begin
					dl_b_s[k] <= side_ah;
				end else begin
					dl_b_s[k] <= dl_b_s[k-1];
				end
				dl_d_s[k] <= dl_d_s[k-1];
			end
		end
	end

endmodule

// ===== tb/rounded_cone_distance_test.sv =====
// rounded_cone_distance_test: drives distance queries through the rounded cone
// pipeline with random idling on both channels and checks every result.
// Depends on rcd_pkg and the rounded_cone_distance top level.
`timescale 1ns / 100ps

module rounded_cone_distance_test;
	import rcd_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] a [3];
		logic signed [COORD_W-1:0] b [3];
		logic signed [COORD_W-1:0] p [3];
		logic [RAD_W-1:0]          ra;
		logic [RAD_W-1:0]          rb;
	} query_t;

	typedef struct {
		logic signed [COORD_W-1:0] dval;
		status_t                   st;
	} answer_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [COORD_W-1:0] end_a_x, end_a_y, end_a_z;
	logic signed [COORD_W-1:0] end_b_x, end_b_y, end_b_z;
	logic [RAD_W-1:0] radius_a, radius_b;
	logic signed [COORD_W-1:0] point_x, point_y, point_z;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_W-1:0] distance;
	logic [1:0] status;

	query_t  pending_queries [$];
	query_t  on_port;
	answer_t expected_answers [$];
	int      mismatch_count = 0;
	int      send_gap = 0;
	int      stall_left = 0;
	bit      port_taken = 0;

	rounded_cone_distance uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.end_a_x(end_a_x), .end_a_y(end_a_y), .end_a_z(end_a_z),
		.end_b_x(end_b_x), .end_b_y(end_b_y), .end_b_z(end_b_z),
		.radius_a(radius_a), .radius_b(radius_b),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .status(status)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] root_floor(input logic [127:0] x);
		logic [63:0] r;
		logic [63:0] c;
		logic [127:0] sq;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			sq = {64'd0, c} * {64'd0, c};
			if (!(x < sq))
				r = c;
		end
		return r;
	endfunction

	function automatic answer_t cone_distance(input query_t q);
		answer_t res;
		logic signed [127:0] d, w, e, hh, ww, ee, dot;
		logic signed [127:0] h, dr, drmag, ah, t, t2, rr, rad, k, ra, rb, raw_dist;
		hh = 0; ww = 0; ee = 0; dot = 0;
		for (int i = 0; i < 3; i++) begin
			d = 128'(q.b[i]) - 128'(q.a[i]);
			w = 128'(q.p[i]) - 128'(q.a[i]);
			e = 128'(q.p[i]) - 128'(q.b[i]);
			hh += d * d;
			ww += w * w;
			ee += e * e;
			dot += w * d;
		end
		res.dval = 0;
		if (hh == 0) begin
			res.st = ST_ZERO_LEN;
			return res;
		end
		h = $signed({64'd0, root_floor(hh)});
		ra = $signed({97'd0, q.ra});
		rb = $signed({97'd0, q.rb});
		dr = ra - rb;
		drmag = dr < 0 ? -dr : dr;
		if (drmag > h) begin
			res.st = ST_RAD_DIFF;
			return res;
		end
		ah = $signed({64'd0, root_floor(h * h - dr * dr)});
		t = dot / h;
		t2 = t * t;
		rr = ww < t2 ? 128'sd0 : ww - t2;
		rad = $signed({64'd0, root_floor(rr)});
		k = ah * t - dr * rad;
		if (k < 0)
			raw_dist = $signed({64'd0, root_floor(ww)}) - ra;
		else if (ah * h < k)
			raw_dist = $signed({64'd0, root_floor(ee)}) - rb;
		else
			raw_dist = (ah * rad + dr * t) / h - ra;
		if (raw_dist > 128'sd2147483647)
			raw_dist = 128'sd2147483647;
		else if (raw_dist < -128'sd2147483648)
			raw_dist = -128'sd2147483648;
		res.dval = raw_dist[COORD_W-1:0];
		res.st = ST_OK;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		mismatch_count++;
	endtask

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// coordinate drawn from a random scale so small and huge values both occur
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			2: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
			default: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
		endcase
	endfunction

	task automatic add_query(input logic signed [31:0] ax, ay, az, bx, by, bz,
			input logic [30:0] ra, rb, input logic signed [31:0] px, py, pz);
		query_t q;
		q.a = '{ax, ay, az};
		q.b = '{bx, by, bz};
		q.p = '{px, py, pz};
		q.ra = ra;
		q.rb = rb;
		pending_queries = {pending_queries, q};
	endtask

	// driver: new item or idle on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || port_taken) begin
				if (send_gap > 0 || pending_queries.size() == 0) begin
					if (send_gap > 0) send_gap--;
					in_valid <= 0;
				end else begin
					on_port = pending_queries.pop_front();
					end_a_x <= on_port.a[0]; end_a_y <= on_port.a[1]; end_a_z <= on_port.a[2];
					end_b_x <= on_port.b[0]; end_b_y <= on_port.b[1]; end_b_z <= on_port.b[2];
					point_x <= on_port.p[0]; point_y <= on_port.p[1]; point_z <= on_port.p[2];
					radius_a <= on_port.ra;
					radius_b <= on_port.rb;
					in_valid <= 1;
					send_gap = idle_length();
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				stall_left = idle_length();
			end
		end
	end

	// monitor: accepted items on both channels
	always @(posedge clk) begin
		answer_t exp_ans;
		port_taken = in_valid && in_ready;
		if (port_taken)
			expected_answers = {expected_answers, cone_distance(on_port)};
		if (out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				exp_ans = expected_answers.pop_front();
				if (status !== exp_ans.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, exp_ans.st));
				if (distance !== exp_ans.dval)
					report_mismatch($sformatf("distance %0d, expected %0d",
						distance, exp_ans.dval));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("rounded_cone_distance verification failed");
		$finish;
	end

	initial begin
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [30:0] ra, rb;
		int kind;
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		{end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z} = '0;
		{point_x, point_y, point_z, radius_a, radius_b} = '0;

		// zero-length segment, and one with nonzero radii
		add_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_query(5, -7, 9, 5, -7, 9, 31'h7fffffff, 3, 100, 200, 300);
		// radius difference above length, and equal to it
		add_query(0, 0, 0, 32'sh10000, 0, 0, 31'h30000, 0, 5, 5, 5);
		add_query(0, 0, 0, 32'sh30000, 0, 0, 31'h30000, 0, 32'sh10000, 32'sh50000, 0);
		add_query(0, 0, 0, 32'sh30000, 0, 0, 0, 31'h30000, 32'sh10000, 32'sh50000, 0);
		// cap at A, cap at B, cone side
		add_query(0, 0, 0, 32'sha0000, 0, 0, 31'h20000, 31'h10000, -32'sh50000, 0, 0);
		add_query(0, 0, 0, 32'sha0000, 0, 0, 31'h20000, 31'h10000, 32'sh100000, 0, 0);
		add_query(0, 0, 0, 32'sha0000, 0, 0, 31'h20000, 31'h10000, 32'sh50000, 32'sh80000, 0);
		add_query(0, 0, 0, 32'sha0000, 0, 0, 31'h20000, 31'h10000, 32'sh50000, 32'sh1000, 0);
		// coordinate and radius extremes, saturation both ways
		add_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		add_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
			0, 0, 0);
		add_query(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0, 0,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		add_query(-1, -1, -1, 0, 0, 0, 1, 0, -1, -1, -1);
		add_query(0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 1);

		for (int n = 0; n < 1700; n++) begin
			kind = $urandom_range(0, 9);
			ax = rand_coord(); ay = rand_coord(); az = rand_coord();
			bx = rand_coord(); by = rand_coord(); bz = rand_coord();
			if (kind == 0) begin
				// fully random fields
				add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					31'($urandom), 31'($urandom), $urandom, $urandom, $urandom);
			end else if (kind == 1) begin
				add_query(ax, ay, az, ax, ay, az, 31'($urandom), 31'($urandom),
					rand_coord(), rand_coord(), rand_coord());
			end else begin
				// radii kept mostly below the length so the geometry is reached
				ra = 31'($urandom_range(0, 32'h30000));
				rb = 31'($urandom_range(0, 32'h30000));
				if (kind == 2) begin
					ra = 31'($urandom);
					rb = 31'($urandom);
				end
				add_query(ax, ay, az, bx, by, bz, ra, rb,
					rand_coord(), rand_coord(), rand_coord());
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (pending_queries.size() == 0 && !in_valid && expected_answers.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && expected_answers.size() == 0)
			$display("rounded_cone_distance verification clean");
		else
			$display("rounded_cone_distance verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
design/rcd_pkg.sv
design/rcd_isqrt.sv
design/rcd_div.sv
design/rounded_cone_distance.sv
tb/rounded_cone_distance_test.sv
